// ===== sv/kpsc_pkg.sv =====
// Package: shared types, key table and constants for the keypad scan block.
`timescale 1ns / 1ps

package kpsc_pkg;

    // Build-time sizing
    localparam int KEY_COUNT   = 12;
    localparam int PULSE_WIDTH = 16;
    localparam int TABLE_KEYS  = 12;
    localparam int KEY_LIMIT   = ((KEY_COUNT & 15) < TABLE_KEYS) ? (KEY_COUNT & 15) : TABLE_KEYS;
    localparam int CNT_W       = (PULSE_WIDTH < 16) ? PULSE_WIDTH : 16;

    // Field widths
    localparam int WORD_W      = 32;
    localparam int KEY_W       = 4;
    localparam int DELAY_W     = 16;
    localparam int PULSE_LEN_W = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 104;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 96;

    // Fixed masks
    localparam logic [WORD_W-1:0] MASK0    = 32'h0002_0000;
    localparam logic [WORD_W-1:0] MASK2    = 32'h0170_01f4;
    localparam logic [WORD_W-1:0] RELEASE2 = MASK2 & ~32'h0170_0000;
    localparam logic [WORD_W-1:0] LOCK_BIT = 32'h0004_0000;
    localparam logic [WORD_W-1:0] USB_BIT  = 32'h0008_0000;
    localparam int                USB_POS  = 19;

    // Register reset values
    localparam logic [DELAY_W-1:0]    FIRST_DELAY_RST  = 16'd500;
    localparam logic [DELAY_W-1:0]    REPEAT_DELAY_RST = 16'd175;
    localparam logic [TABLE_KEYS-1:0] ACTIVE_HIGH_RST  = 12'd2160;

    typedef enum logic [1:0] {
        CMD_SCAN        = 2'd0,
        CMD_PRESS       = 2'd1,
        CMD_RELEASE     = 2'd2,
        CMD_RELEASE_ALL = 2'd3
    } cmd_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_REMOTE_MASK   = 2'd0,
        REG_FIRST_DELAY   = 2'd1,
        REG_REPEAT_DELAY  = 2'd2,
        REG_ACTIVE_HIGH   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic                  remote_mask;
        logic [DELAY_W-1:0]    first_delay;
        logic [DELAY_W-1:0]    repeat_delay;
        logic [TABLE_KEYS-1:0] active_high;
    } cfg_t;

    // Switch mask of each key; keys past the table have none
    function automatic logic [WORD_W-1:0] key_mask(input logic [KEY_W-1:0] idx);
        logic [WORD_W-1:0] m;
        unique case (idx)
            4'd0:    m = 32'h0002_0000;
            4'd1:    m = 32'h0000_0030;
            4'd2:    m = 32'h0000_0020;
            4'd3:    m = 32'h0000_0010;
            4'd4:    m = 32'h0010_0000;
            4'd5:    m = 32'h0020_0000;
            4'd6:    m = 32'h0040_0000;
            4'd7:    m = 32'h0000_0004;
            4'd8:    m = 32'h0000_0100;
            4'd9:    m = 32'h0000_0080;
            4'd10:   m = 32'h0000_0040;
            4'd11:   m = 32'h0100_0000;
            default: m = '0;
        endcase
        return m;
    endfunction

    // 1 when the key lives in group 2, 0 for group 0
    function automatic logic key_in_g2(input logic [KEY_W-1:0] idx);
        return (idx >= 4'd1) && (idx <= 4'd11);
    endfunction

endpackage

// ===== sv/kpsc_cfg.sv =====
// Configuration register file of the keypad scan block.
`timescale 1ns / 1ps

module kpsc_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [kpsc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [kpsc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output kpsc_pkg::cfg_t                     cfg
);
    import kpsc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_addr))
                REG_REMOTE_MASK:   cfg_next.remote_mask   = cfg_data[0];
                REG_FIRST_DELAY:   cfg_next.first_delay   = cfg_data[DELAY_W-1:0];
                REG_REPEAT_DELAY:  cfg_next.repeat_delay  = cfg_data[DELAY_W-1:0];
                REG_ACTIVE_HIGH:   cfg_next.active_high   = cfg_data[TABLE_KEYS-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.remote_mask   <= 1'b0;
            cfg_reg.first_delay   <= FIRST_DELAY_RST;
            cfg_reg.repeat_delay  <= REPEAT_DELAY_RST;
            cfg_reg.active_high   <= ACTIVE_HIGH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/kpsc_keys.sv =====
// Per-key pressed decode of a group 0 / group 2 word pair, honoring key polarity.
`timescale 1ns / 1ps

module kpsc_keys
(
    input  logic [kpsc_pkg::WORD_W-1:0]     word0,
    input  logic [kpsc_pkg::WORD_W-1:0]     word2,
    input  logic [kpsc_pkg::TABLE_KEYS-1:0] active_high,
    output logic [kpsc_pkg::TABLE_KEYS-1:0] pressed
);
    import kpsc_pkg::*;

    // One bit per key; keys at or past the key limit never read pressed
    always_comb
    begin
        logic [WORD_W-1:0] w;
        logic              hit;
        pressed = '0;
        for (int i = 0; i < TABLE_KEYS; i++)
        begin
            w   = key_in_g2(KEY_W'(i)) ? word2 : word0;
            hit = |(w & key_mask(KEY_W'(i)));
            if (i < KEY_LIMIT)
            begin
                pressed[i] = active_high[i] ? hit : !hit;
            end
        end
    end

endmodule

// ===== sv/keypad_scan_click_autorepeat.sv =====
// Keypad scan with override merge, click detect, autorepeat and remote pulse timing.
// Each scan passes through two registers: the input register, loaded at its input transfer,
// and the result register, loaded from it. Throughput: one item per cycle, set by the
// combinational decode between the two registers; a scan waits while the result
// register holds an untaken result. Press, release and release-all commands give no result.
// Reset (rst_n, async, active low) empties both stages, loads register defaults,
// releases all override keys and clears the key history and remote counter.
`timescale 1ns / 1ps

module keypad_scan_click_autorepeat
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Config write port
    input  logic                                 cfg_we,
    input  logic [kpsc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [kpsc_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // raw_group0[31:0], raw_group2[63:32], tick_now[95:64], override_on[96],
    // key_index[100:97], zero pad[103:101]
    input  logic [kpsc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // command[1:0]
    input  logic [kpsc_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    // Result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // out_group0[31:0], out_group2[63:32], pressed_key[67:64], clicked_key[71:68],
    // repeat_key[75:72], remote_level[76], pulse_done[77], pulse_length[93:78],
    // zero pad[95:94]
    output logic [kpsc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import kpsc_pkg::*;

    cfg_t cfg;

    // Input stage
    logic              in_valid_reg;
    cmd_t              cmd_reg;
    logic [WORD_W-1:0] r0_reg;
    logic [WORD_W-1:0] r2_reg;
    logic [WORD_W-1:0] tick_reg;
    logic              ovon_reg;
    logic [KEY_W-1:0]  kidx_reg;

    // Block state
    logic [WORD_W-1:0] prev0_reg, prev0_next;
    logic [WORD_W-1:0] prev2_reg, prev2_next;
    logic [WORD_W-1:0] ov0_reg, ov0_next;
    logic [WORD_W-1:0] ov2_reg, ov2_next;
    logic [KEY_W-1:0]  held_reg, held_next;
    logic [WORD_W-1:0] last_tick_reg, last_tick_next;
    logic              repeating_reg, repeating_next;
    logic [CNT_W-1:0]  remote_cnt_reg, remote_cnt_next;

    // Result stage
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic                  out_free;
    logic                  advance;
    logic                  is_scan;
    logic [TABLE_KEYS-1:0] cur_pressed;
    logic [TABLE_KEYS-1:0] prev_pressed;
    logic [TABLE_KEYS-1:0] new_click;

    kpsc_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    kpsc_keys u_keys_cur
    (
        .word0       (r0_reg),
        .word2       (r2_reg),
        .active_high (cfg.active_high),
        .pressed     (cur_pressed)
    );

    kpsc_keys u_keys_prev
    (
        .word0       (prev0_reg),
        .word2       (prev2_reg),
        .active_high (cfg.active_high),
        .pressed     (prev_pressed)
    );

    // Handshake: commands drain without a result, scans need room in the result stage
    assign is_scan       = (cmd_reg == CMD_SCAN);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!is_scan || out_free);
    assign s_axis_tready = !in_valid_reg || advance;
    assign new_click     = cur_pressed & ~prev_pressed;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cmd_reg  <= cmd_t'(s_axis_tuser[1:0]);
            r0_reg   <= s_axis_tdata[31:0];
            r2_reg   <= s_axis_tdata[63:32];
            tick_reg <= s_axis_tdata[95:64];
            ovon_reg <= s_axis_tdata[96];
            kidx_reg <= s_axis_tdata[100:97];
        end
    end

    // Item processing
    always_comb
    begin
        logic [WORD_W-1:0]     kmask;
        logic [KEY_W-1:0]      prs;
        logic [KEY_W-1:0]      clk_key;
        logic [KEY_W-1:0]      rep;
        logic [2*TABLE_KEYS-1:0] held_vec;
        logic                  held_down;
        logic [DELAY_W-1:0]    lim;
        logic [WORD_W-1:0]     elapsed;
        logic [WORD_W-1:0]     m0;
        logic [WORD_W-1:0]     m2;
        logic                  level;
        logic                  done;
        logic [CNT_W-1:0]      len;

        prev0_next      = prev0_reg;
        prev2_next      = prev2_reg;
        ov0_next        = ov0_reg;
        ov2_next        = ov2_reg;
        held_next       = held_reg;
        last_tick_next  = last_tick_reg;
        repeating_next  = repeating_reg;
        remote_cnt_next = remote_cnt_reg;

        kmask = key_mask(kidx_reg);

        // Priority encode, lowest key index wins
        prs     = '0;
        clk_key = '0;
        for (int i = TABLE_KEYS - 1; i >= 0; i--)
        begin
            if (cur_pressed[i])
            begin
                prs = KEY_W'(i + 1);
            end
            if (new_click[i])
            begin
                clk_key = KEY_W'(i + 1);
            end
        end

        // Held key still down; index zero (no key) wraps into the zero padding
        held_vec  = {{TABLE_KEYS{1'b0}}, cur_pressed};
        held_down = (held_reg != '0) && held_vec[5'(held_reg - 4'd1)];
        lim       = repeating_reg ? cfg.repeat_delay : cfg.first_delay;
        elapsed   = tick_reg - last_tick_reg;

        // Override merge
        if (ovon_reg)
        begin
            m0 = (r0_reg | MASK0) & (~MASK0 | ov0_reg);
            m2 = (r2_reg | MASK2) & (~MASK2 | ov2_reg);
        end
        else
        begin
            m0 = r0_reg;
            m2 = r2_reg;
        end
        level = m2[USB_POS];
        done  = 1'b0;
        len   = '0;
        rep   = '0;

        if (advance)
        begin
            unique case (cmd_reg)
                CMD_PRESS:
                begin
                    if (kidx_reg < KEY_W'(KEY_LIMIT))
                    begin
                        if (key_in_g2(kidx_reg))
                        begin
                            ov2_next = ov2_reg & ~kmask;
                        end
                        else
                        begin
                            ov0_next = ov0_reg & ~kmask;
                        end
                    end
                end
                CMD_RELEASE:
                begin
                    if (kidx_reg < KEY_W'(KEY_LIMIT))
                    begin
                        if (key_in_g2(kidx_reg))
                        begin
                            ov2_next = ov2_reg | kmask;
                        end
                        else
                        begin
                            ov0_next = ov0_reg | kmask;
                        end
                    end
                end
                CMD_RELEASE_ALL:
                begin
                    ov0_next = ov0_reg | MASK0;
                    ov2_next = ov2_reg | RELEASE2;
                end
                CMD_SCAN:
                begin
                    // Click and autorepeat
                    priority if (clk_key != '0)
                    begin
                        held_next      = clk_key;
                        repeating_next = 1'b0;
                        last_tick_next = tick_reg;
                        rep            = clk_key;
                    end
                    else if (held_down)
                    begin
                        if (elapsed > {{(WORD_W-DELAY_W){1'b0}}, lim})
                        begin
                            repeating_next = 1'b1;
                            last_tick_next = tick_reg;
                            rep            = held_reg;
                        end
                    end
                    else
                    begin
                        held_next = '0;
                    end

                    prev0_next = r0_reg;
                    prev2_next = r2_reg;

                    // Remote pulse timing, saturating
                    if (level)
                    begin
                        if (remote_cnt_reg != '1)
                        begin
                            remote_cnt_next = remote_cnt_reg + CNT_W'(1);
                        end
                    end
                    else if (remote_cnt_reg != '0)
                    begin
                        done            = 1'b1;
                        len             = remote_cnt_reg;
                        remote_cnt_next = '0;
                    end
                end
            endcase
        end

        m2 = m2 & ~(LOCK_BIT | (cfg.remote_mask ? USB_BIT : '0));

        out_data_next = {2'b00, PULSE_LEN_W'(len), done, level, rep, clk_key, prs, m2, m0};

        // Result register load / drain
        if (advance && is_scan)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev0_reg      <= '0;
            prev2_reg      <= '0;
            ov0_reg        <= MASK0;
            ov2_reg        <= RELEASE2;
            held_reg       <= '0;
            last_tick_reg  <= '0;
            repeating_reg  <= 1'b0;
            remote_cnt_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prev0_reg      <= prev0_next;
            prev2_reg      <= prev2_next;
            ov0_reg        <= ov0_next;
            ov2_reg        <= ov2_next;
            held_reg       <= held_next;
            last_tick_reg  <= last_tick_next;
            repeating_reg  <= repeating_next;
            remote_cnt_reg <= remote_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance && is_scan)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
